### src/assert_macros.svh
// Assertion macros shared by the line packer RTL.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition that must hold at every clock edge outside reset.
`define TBLP_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define TBLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define TBLP_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define TBLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### src/tblp_pkg.sv
// Types and constants of the BASIC text line packer.
// Depends on nothing; used by tblp_decode and text_to_basic_line_packer.
package tblp_pkg;

  // Input item: kind then raw text byte.
  typedef struct packed {
    logic       kind;
    logic [7:0] text_byte;
  } in_item_t;

  // Result item: one packed program byte and the end flag.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] END_MARK  = 8'h80;
  localparam logic [7:0] LINE_END  = 8'h00;
  localparam logic [7:0] TEXT_STOP = 8'h00;

  // Parsing phase, one-hot.
  typedef enum logic [3:0] {
    PH_SKIP   = 4'b0001,
    PH_DIGITS = 4'b0010,
    PH_BODY   = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  // Up to three result items caused by one input item.
  typedef struct packed {
    logic [1:0]           cnt;
    out_item_t [2:0]      item;
  } tblp_res_t;

endpackage

### src/tblp_decode.sv
// Combinational decode of one input item against the parser state.
// Depends on tblp_pkg for item types, phase codes and character constants.
module tblp_decode (
  input  tblp_pkg::in_item_t  item,
  input  tblp_pkg::phase_t    phase,
  input  logic [15:0]         num,
  output tblp_pkg::phase_t    phase_nxt,
  output logic [15:0]         num_nxt,
  output tblp_pkg::tblp_res_t res
);

  logic [7:0]  b;
  logic        is_digit;
  logic        is_eol;
  logic [15:0] num_sel;
  logic [15:0] num_acc;

  assign b        = item.text_byte;
  assign is_digit = (b >= tblp_pkg::CH_ZERO) && (b <= tblp_pkg::CH_NINE);
  assign is_eol   = (b == tblp_pkg::CH_LF) || (b == tblp_pkg::CH_CR);
  // A line without digits carries number zero.
  assign num_sel  = (phase == tblp_pkg::PH_SKIP) ? 16'd0 : num;
  // num * 10 + digit, kept to 16 bits.
  assign num_acc  = {num[12:0], 3'b000} + {num[14:0], 1'b0} + {12'd0, b[3:0]};

  always_comb begin
    phase_nxt = phase;
    num_nxt   = num;
    res       = '0;
    if (item.kind == tblp_pkg::KIND_END || b == tblp_pkg::TEXT_STOP) begin
      // End of text: pending number bytes, then the end marker.
      if (phase != tblp_pkg::PH_DONE) begin
        if (phase == tblp_pkg::PH_DIGITS) begin
          res.cnt     = 2'd3;
          res.item[0] = '{out_byte: num[15:8], last: 1'b0};
          res.item[1] = '{out_byte: num[7:0], last: 1'b0};
          res.item[2] = '{out_byte: tblp_pkg::END_MARK, last: 1'b1};
        end else begin
          res.cnt     = 2'd1;
          res.item[0] = '{out_byte: tblp_pkg::END_MARK, last: 1'b1};
        end
      end
      num_nxt = 16'd0;
      if (item.kind == tblp_pkg::KIND_END) begin
        phase_nxt = tblp_pkg::PH_SKIP;
      end else begin
        phase_nxt = tblp_pkg::PH_DONE;
      end
    end else begin
      unique case (phase)
        tblp_pkg::PH_SKIP, tblp_pkg::PH_DIGITS: begin
          if (phase == tblp_pkg::PH_SKIP && b == tblp_pkg::CH_LF) begin
            // Blank line feed before a line is dropped.
          end else if (is_digit) begin
            num_nxt   = (phase == tblp_pkg::PH_SKIP) ? {12'd0, b[3:0]} : num_acc;
            phase_nxt = tblp_pkg::PH_DIGITS;
          end else begin
            // Number finished: emit it, then treat the byte after it.
            res.item[0] = '{out_byte: num_sel[15:8], last: 1'b0};
            res.item[1] = '{out_byte: num_sel[7:0], last: 1'b0};
            num_nxt     = 16'd0;
            if (b == tblp_pkg::CH_SPACE) begin
              res.cnt   = 2'd2;
              phase_nxt = tblp_pkg::PH_BODY;
            end else if (is_eol) begin
              res.cnt     = 2'd3;
              res.item[2] = '{out_byte: tblp_pkg::LINE_END, last: 1'b0};
              phase_nxt   = tblp_pkg::PH_SKIP;
            end else begin
              res.cnt     = 2'd3;
              res.item[2] = '{out_byte: b, last: 1'b0};
              phase_nxt   = tblp_pkg::PH_BODY;
            end
          end
        end
        tblp_pkg::PH_BODY: begin
          res.cnt = 2'd1;
          if (is_eol) begin
            res.item[0] = '{out_byte: tblp_pkg::LINE_END, last: 1'b0};
            phase_nxt   = tblp_pkg::PH_SKIP;
          end else begin
            res.item[0] = '{out_byte: b, last: 1'b0};
          end
        end
        tblp_pkg::PH_DONE: begin
          // Text bytes after a zero byte are ignored.
        end
        default: begin
          phase_nxt = tblp_pkg::PH_SKIP;
          num_nxt   = 16'd0;
        end
      endcase
    end
  end

endmodule

### src/text_to_basic_line_packer.sv
// Top level of the BASIC text line packer: state, result buffer, handshakes.
// Depends on tblp_pkg, tblp_decode and assert_macros.svh.
//
//  channel | ports                        | payload
//  --------+------------------------------+--------------------------
//  input   | in_valid, in_ready, in_data  | kind, text_byte
//  result  | out_valid, out_ready, out_data | out_byte, last
//
// An item is decoded in the cycle it is accepted; its up to three results
// land in a three-entry result buffer and, while out_ready is high, leave one
// per cycle from the next. A new item is accepted when the buffer is empty or
// drains its last entry in that cycle, so items with at most one result flow
// at that rate, and other items hold the input until one result is left.
// Synchronous active-low reset clears the phase, line number and buffer count.
`include "assert_macros.svh"

module text_to_basic_line_packer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tblp_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tblp_pkg::out_item_t  out_data
);

  tblp_pkg::phase_t          phase_r, phase_nxt, dec_phase;
  logic [15:0]               num_r, num_nxt, dec_num;
  tblp_pkg::tblp_res_t       dec_res;
  tblp_pkg::out_item_t [2:0] buf_r, buf_nxt;
  logic [1:0]                cnt_r, cnt_nxt;
  logic                      in_acc;
  logic                      out_acc;

  tblp_decode u_decode (
    .item      (in_data),
    .phase     (phase_r),
    .num       (num_r),
    .phase_nxt (dec_phase),
    .num_nxt   (dec_num),
    .res       (dec_res)
  );

  // Handshakes.
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = buf_r[0];
  assign out_acc   = out_valid && out_ready;
  assign in_ready  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);
  assign in_acc    = in_valid && in_ready;

  // Parser state advances on each accepted item.
  always_comb begin
    phase_nxt = phase_r;
    num_nxt   = num_r;
    if (in_acc) begin
      phase_nxt = dec_phase;
      num_nxt   = dec_num;
    end
  end

  // Result buffer: load on accept, otherwise shift out on each taken item.
  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (in_acc) begin
      buf_nxt = dec_res.item;
      cnt_nxt = dec_res.cnt;
    end else if (out_acc) begin
      buf_nxt[0] = buf_r[1];
      buf_nxt[1] = buf_r[2];
      cnt_nxt    = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tblp_pkg::PH_SKIP;
      num_r   <= 16'd0;
      cnt_r   <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      num_r   <= num_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  // The end marker is always the final entry of the buffer.
  `TBLP_ASSERT_ALWAYS(a_last_at_tail, clk, rst_n, !(out_valid && out_data.last) || cnt_r == 2'd1, "end marker is not the last buffered item")
  // An end item always rearms the parser.
  `TBLP_ASSERT_NEXT(a_end_rearms, clk, rst_n, in_acc && in_data.kind == tblp_pkg::KIND_END, phase_r == tblp_pkg::PH_SKIP && num_r == 16'd0, "end item did not rearm the parser")
  // A line number is only held while digits are collected.
  `TBLP_ASSERT_ALWAYS(a_num_in_digits, clk, rst_n, phase_r == tblp_pkg::PH_DIGITS || num_r == 16'd0, "line number held outside digit phase")

endmodule

### tb/tb.sv
// Self-checking testbench for the BASIC text line packer: directed and random program text.
// It predicts the packed image bytes and compares each result item with the oldest prediction.
// Depends on tblp_pkg and text_to_basic_line_packer.
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int QUIET_TAIL    = 40;
  localparam int HOLD_AT       = 45;
  localparam int HOLD_CYCLES   = 60;
  localparam int SETTLE_CYCLES = 20;
  localparam int TEXT_TARGET   = 200;

  // One pending input item; wait_empty makes the sender drain the block first.
  typedef struct {
    tblp_pkg::in_item_t item;
    bit                 wait_empty;
  } text_slot_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  tblp_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  tblp_pkg::out_item_t out_data;

  text_slot_t          text_items[$];
  tblp_pkg::out_item_t image_due[$];
  bit                  wait_next = 1'b0;

  int accepted_count  = 0;
  int expected_count  = 0;
  int predicted_total = 0;
  int seen_count      = 0;
  int error_count     = 0;
  int total_items     = 0;
  int cycle_count     = 0;
  int gap_left        = 0;
  int stall_left      = 0;
  bit long_hold_done  = 1'b0;
  logic quiet;

  // Predicted parser state.
  tblp_pkg::phase_t pk_phase   = tblp_pkg::PH_SKIP;
  logic [15:0]      pk_line_no = '0;

  assign quiet = (accepted_count + QUIET_TAIL >= total_items);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  text_to_basic_line_packer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Predictor of the packed image.
  function automatic void emit(logic [7:0] b, logic last);
    tblp_pkg::out_item_t r;
    r.out_byte = b;
    r.last     = last;
    image_due.push_back(r);
    predicted_total++;
  endfunction

  function automatic void emit_line_no();
    emit(pk_line_no[15:8], 1'b0);
    emit(pk_line_no[7:0], 1'b0);
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return (b >= tblp_pkg::CH_ZERO) && (b <= tblp_pkg::CH_NINE);
  endfunction

  // End of text: a number still being collected goes out before the end marker.
  function automatic void close_text();
    if (pk_phase == tblp_pkg::PH_DIGITS) emit_line_no();
    emit(tblp_pkg::END_MARK, 1'b1);
    pk_line_no = '0;
  endfunction

  // The line number is complete; the byte that ended it is dropped, ends the line or is copied.
  function automatic void end_line_no(logic [7:0] b);
    emit_line_no();
    pk_line_no = '0;
    if (b == tblp_pkg::CH_SPACE) begin
      pk_phase = tblp_pkg::PH_BODY;
    end else if (b == tblp_pkg::CH_LF || b == tblp_pkg::CH_CR) begin
      emit(tblp_pkg::LINE_END, 1'b0);
      pk_phase = tblp_pkg::PH_SKIP;
    end else begin
      emit(b, 1'b0);
      pk_phase = tblp_pkg::PH_BODY;
    end
  endfunction

  function automatic void pack_item(tblp_pkg::in_item_t it);
    logic [7:0] b;
    b = it.text_byte;
    if (it.kind == tblp_pkg::KIND_END) begin
      if (pk_phase != tblp_pkg::PH_DONE) close_text();
      pk_phase   = tblp_pkg::PH_SKIP;
      pk_line_no = '0;
    end else if (pk_phase != tblp_pkg::PH_DONE) begin
      if (b == tblp_pkg::TEXT_STOP) begin
        close_text();
        pk_phase = tblp_pkg::PH_DONE;
      end else begin
        case (pk_phase)
          tblp_pkg::PH_SKIP: begin
            if (is_digit(b)) begin
              pk_line_no = 16'(b - tblp_pkg::CH_ZERO);
              pk_phase   = tblp_pkg::PH_DIGITS;
            end else if (b != tblp_pkg::CH_LF) begin
              pk_line_no = '0;
              end_line_no(b);
            end
          end
          tblp_pkg::PH_DIGITS: begin
            if (is_digit(b)) pk_line_no = pk_line_no * 16'd10 + 16'(b - tblp_pkg::CH_ZERO);
            else end_line_no(b);
          end
          default: begin
            if (b == tblp_pkg::CH_LF || b == tblp_pkg::CH_CR) begin
              emit(tblp_pkg::LINE_END, 1'b0);
              pk_phase = tblp_pkg::PH_SKIP;
            end else begin
              emit(b, 1'b0);
            end
          end
        endcase
      end
    end
  endfunction

  // Stimulus builders.
  function automatic void push_item(logic kind, logic [7:0] b);
    text_slot_t s;
    s.item.kind      = kind;
    s.item.text_byte = b;
    s.wait_empty     = wait_next;
    wait_next        = 1'b0;
    text_items.push_back(s);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_item(tblp_pkg::KIND_TEXT, s[i]);
  endfunction

  function automatic void push_end();
    push_item(tblp_pkg::KIND_END, 8'($urandom_range(0, 255)));
  endfunction

  function automatic logic [7:0] body_byte();
    case ($urandom_range(0, 11))
      0:       return 8'($urandom_range(0, 255));
      1, 2:    return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(33, 126));
    endcase
  endfunction

  // A well-formed program: lines with optional numbers, text and line ends.
  function automatic void queue_program();
    int lines;
    lines = $urandom_range(1, 4);
    for (int l = 0; l < lines; l++) begin
      repeat ($urandom_range(0, 2)) push_item(tblp_pkg::KIND_TEXT, tblp_pkg::CH_LF);
      repeat ($urandom_range(0, 5))
        push_item(tblp_pkg::KIND_TEXT, tblp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 2) != 0) push_item(tblp_pkg::KIND_TEXT, tblp_pkg::CH_SPACE);
      repeat ($urandom_range(0, 6)) push_item(tblp_pkg::KIND_TEXT, body_byte());
      case ($urandom_range(0, 2))
        0: push_item(tblp_pkg::KIND_TEXT, tblp_pkg::CH_LF);
        1: push_item(tblp_pkg::KIND_TEXT, tblp_pkg::CH_CR);
        default: begin
          push_item(tblp_pkg::KIND_TEXT, tblp_pkg::CH_CR);
          push_item(tblp_pkg::KIND_TEXT, tblp_pkg::CH_LF);
        end
      endcase
    end
    // Every text closes with an end item; some first stop on a zero byte and carry trailing junk.
    if ($urandom_range(0, 4) == 0) begin
      push_item(tblp_pkg::KIND_TEXT, tblp_pkg::TEXT_STOP);
      repeat ($urandom_range(0, 3))
        push_item(tblp_pkg::KIND_TEXT, 8'($urandom_range(0, 255)));
    end
    push_end();
  endfunction

  // Raw noise: any byte, with the odd end item mixed in.
  function automatic void queue_noise();
    repeat ($urandom_range(4, 10)) begin
      if ($urandom_range(0, 5) == 0) push_end();
      else push_item(tblp_pkg::KIND_TEXT, 8'($urandom_range(0, 255)));
    end
    push_end();
  endfunction

  // Sender: offers the pending items, with random gaps, and drains the block first where an item asks for it.
  always @(posedge clk) begin : driver
    text_slot_t slot;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        pack_item(in_data);
        accepted_count <= accepted_count + 1;
        expected_count <= predicted_total;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (text_items.size() != 0 &&
                     !(text_items[0].wait_empty &&
                       ((in_valid && in_ready) || expected_count != seen_count))) begin
          slot = text_items.pop_front();
          in_valid <= 1'b1;
          in_data  <= slot.item;
          if (!quiet && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result item and stalls at random, once for a long stretch.
  always @(posedge clk) begin : monitor
    tblp_pkg::out_item_t exp_item;
    int                  errs;
    errs = 0;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        seen_count <= seen_count + 1;
        if (image_due.size() == 0) begin
          $display("%0t: unexpected image byte %02h last %0b", $time,
                   out_data.out_byte, out_data.last);
          errs++;
        end else begin
          exp_item = image_due.pop_front();
          if (out_data.out_byte !== exp_item.out_byte) begin
            $display("%0t: image byte mismatch, expected %02h got %02h", $time,
                     exp_item.out_byte, out_data.out_byte);
            errs++;
          end
          if (out_data.last !== exp_item.last) begin
            $display("%0t: last flag mismatch, expected %0b got %0b", $time,
                     exp_item.last, out_data.last);
            errs++;
          end
        end
      end
      if (!long_hold_done && accepted_count >= HOLD_AT) begin
        long_hold_done <= 1'b1;
        stall_left     <= HOLD_CYCLES;
        out_ready      <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 6);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      error_count <= error_count + errs;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("text_to_basic_line_packer verification failed");
      $finish;
    end
  end

  initial begin
    // Directed text: corner cases of numbers, line ends and text termination.
    push_end();                                      // end item straight after reset
    push_item(tblp_pkg::KIND_TEXT, tblp_pkg::CH_LF); // leading line feed is skipped
    push_text("70000 ");                             // number wraps, following space dropped
    push_item(tblp_pkg::KIND_TEXT, 8'hFF);
    push_item(tblp_pkg::KIND_TEXT, tblp_pkg::CH_CR);
    push_text("10");
    push_item(tblp_pkg::KIND_TEXT, tblp_pkg::CH_LF); // line feed right after the number
    push_item(tblp_pkg::KIND_TEXT, tblp_pkg::CH_CR); // carriage return on an empty line
    push_text("A");                                  // line without a number
    push_item(tblp_pkg::KIND_TEXT, tblp_pkg::CH_LF);
    push_text("1");
    push_end();                                      // end while collecting digits
    push_item(tblp_pkg::KIND_TEXT, tblp_pkg::TEXT_STOP); // zero byte ends the text
    push_text("Q");
    push_item(tblp_pkg::KIND_TEXT, tblp_pkg::TEXT_STOP); // ignored once stopped
    push_end();                                      // rearm, no output
    push_text("5");
    push_item(tblp_pkg::KIND_TEXT, tblp_pkg::TEXT_STOP); // zero byte while collecting digits
    push_end();
    push_text("B");
    push_end();                                      // end inside line text

    // Random programs; now and then the sender waits for the block to drain.
    wait_next = 1'b1;
    for (int k = 1; text_items.size() < TEXT_TARGET; k++) begin
      if (k % 6 == 0) wait_next = 1'b1;
      if ($urandom_range(0, 7) == 0) queue_noise();
      else queue_program();
    end
    total_items = text_items.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count != total_items || seen_count != expected_count) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0 && seen_count == expected_count && image_due.size() == 0) begin
      $display("text_to_basic_line_packer verification clean");
    end else begin
      $display("text_to_basic_line_packer verification failed");
    end
    $finish;
  end

endmodule
